### design/sscnt_pkg.sv
// ---------------------------------------------------------------------------
// sscnt_pkg
// Shared widths, constants and control types of the subset sum counter.
// ---------------------------------------------------------------------------
package sscnt_pkg;

  localparam int VALUE_W            = 16;
  localparam int TARGET_W           = 10;
  localparam int COUNT_W            = 63;
  localparam int MAX_TARGET_DEFAULT = 1023;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control handed from the sequencer to the datapath
  typedef struct packed {
    logic start;      // item transfer this cycle
    logic reset_ovf;  // item starts a new set
    logic wr;         // update stage holds a valid entry
    logic clr;        // table contents read as freshly cleared
    logic use_b;      // entry s-value exists
    logic deliver;    // move the result to the output register
  } step_ctl_t;

endpackage

### design/sscnt_if.sv
// ---------------------------------------------------------------------------
// sscnt_if
// Channel interfaces: input items, result items and the target register.
// ---------------------------------------------------------------------------
interface sscnt_in_if;
  import sscnt_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               new_set;
  modport source (output valid, value, new_set, input ready);
  modport sink (input valid, value, new_set, output ready);
endinterface

interface sscnt_out_if;
  import sscnt_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] subset_count;
  logic               saturated;
  modport source (output valid, subset_count, saturated, input ready);
  modport sink (input valid, subset_count, saturated, output ready);
endinterface

interface sscnt_cfg_if;
  import sscnt_pkg::*;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_sum;
  modport source (output valid, target_sum, input ready);
  modport sink (input valid, target_sum, output ready);
endinterface

### design/subset_sum_count.sv
// ---------------------------------------------------------------------------
// subset_sum_count
// Counts subsets of a value stream whose sum equals the target register.
// ---------------------------------------------------------------------------
// channel  modport  payload
// in_ch    sink     value[15:0], new_set
// out_ch   source   subset_count[62:0], saturated
// cfg      sink     target_sum[9:0], always ready
//
// each item walks the count memory with one read-modify-write per cycle, one entry
// each, from the top entry down to entry zero, then drains and hands off; no new item
// is taken until the walk is through; the memory's single write port sets this rate
// reset needs no clearing pass: the first item after reset sees an empty table
// a result waiting on out_ch does not stop the next item being taken; only the
// hand-off of a finished walk waits for the output register to free
module subset_sum_count
  import sscnt_pkg::*;
#(
  parameter int MAX_TARGET = MAX_TARGET_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sscnt_in_if.sink    in_ch,
  sscnt_out_if.source out_ch,
  sscnt_cfg_if.sink   cfg
);

  localparam int DEPTH = MAX_TARGET + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [TARGET_W-1:0] target_sum;
  step_ctl_t           ctl;
  logic [AW-1:0]       raddr_a;
  logic [AW-1:0]       raddr_b;
  logic [AW-1:0]       p_addr;
  logic [AW-1:0]       p_addr_b;
  logic [COUNT_W-1:0]  rd_a;
  logic [COUNT_W-1:0]  rd_b;
  logic [COUNT_W-1:0]  wr_data;
  logic                out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg.valid) begin
      target_sum <= cfg.target_sum;
    end
  end

  sscnt_ctrl #(
    .MAX_TARGET (MAX_TARGET),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .value    (in_ch.value),
    .new_set  (in_ch.new_set),
    .out_free (out_free),
    .ctl      (ctl),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .p_addr   (p_addr),
    .p_addr_b (p_addr_b)
  );

  sscnt_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .we      (ctl.wr),
    .waddr   (p_addr),
    .wdata   (wr_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  sscnt_datapath #(
    .AW (AW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .p_addr       (p_addr),
    .p_addr_b     (p_addr_b),
    .target_sum   (target_sum),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .wr_data      (wr_data),
    .out_free     (out_free),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .subset_count (out_ch.subset_count),
    .saturated    (out_ch.saturated)
  );

endmodule

### design/sscnt_table.sv
// ---------------------------------------------------------------------------
// sscnt_table
// Count memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module sscnt_table
  import sscnt_pkg::*;
#(
  parameter int DEPTH = MAX_TARGET_DEFAULT + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output logic [COUNT_W-1:0] rdata_a,
  output logic [COUNT_W-1:0] rdata_b
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/sscnt_datapath.sv
// ---------------------------------------------------------------------------
// sscnt_datapath
// Shared saturating adder, target capture, overflow flag, output register.
// ---------------------------------------------------------------------------
module sscnt_datapath
  import sscnt_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  step_ctl_t           ctl,
  input  logic [AW-1:0]       p_addr,
  input  logic [AW-1:0]       p_addr_b,
  input  logic [TARGET_W-1:0] target_sum,
  input  logic [COUNT_W-1:0]  rd_a,
  input  logic [COUNT_W-1:0]  rd_b,
  output logic [COUNT_W-1:0]  wr_data,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  subset_count,
  output logic                saturated
);

  logic [COUNT_W-1:0] opa;
  logic [COUNT_W-1:0] opb;
  logic [COUNT_W:0]   sum;
  logic               sat;
  logic [COUNT_W-1:0] result;
  logic               overflow_seen;

  // a cleared table holds one at entry zero only
  always_comb begin
    if (ctl.clr) begin
      opa = COUNT_W'(p_addr == '0);
    end else begin
      opa = rd_a;
    end
    if (!ctl.use_b) begin
      opb = '0;
    end else if (ctl.clr) begin
      opb = COUNT_W'(p_addr_b == '0);
    end else begin
      opb = rd_b;
    end
    sum     = {1'b0, opa} + {1'b0, opb};
    sat     = sum[COUNT_W];
    wr_data = sat ? COUNT_MAX : sum[COUNT_W-1:0];
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (ctl.reset_ovf) begin
        overflow_seen <= 1'b0;
      end else if (ctl.wr && sat) begin
        overflow_seen <= 1'b1;
      end
      if (ctl.deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a target beyond the table never matches and reports zero
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      result <= '0;
    end else if (ctl.wr && (32'(target_sum) == 32'(p_addr))) begin
      result <= wr_data;
    end
    if (ctl.deliver) begin
      subset_count <= result;
      saturated    <= overflow_seen;
    end
  end

endmodule

### design/sscnt_ctrl.sv
// ---------------------------------------------------------------------------
// sscnt_ctrl
// Sequencer: walks the table from the top entry down to entry zero.
// ---------------------------------------------------------------------------
module sscnt_ctrl
  import sscnt_pkg::*;
#(
  parameter int MAX_TARGET = MAX_TARGET_DEFAULT,
  parameter int AW         = $clog2(MAX_TARGET + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  input  logic               new_set,
  input  logic               out_free,
  output step_ctl_t          ctl,
  output logic [AW-1:0]      raddr_a,
  output logic [AW-1:0]      raddr_b,
  output logic [AW-1:0]      p_addr,
  output logic [AW-1:0]      p_addr_b
);

  state_t             state;
  state_t             state_next;
  logic [AW-1:0]      idx;
  logic [VALUE_W-1:0] val;
  logic               clr;
  logic               pending;
  logic               p_valid;
  logic               p_use_b;
  logic               issue;
  logic               start;
  logic               use_b;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_WALK;
      ST_WALK:   if (idx == '0) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    start         = in_valid && in_ready;
    issue         = (state == ST_WALK);
    ctl.start     = start;
    ctl.reset_ovf = start && (new_set || pending);
    ctl.wr        = p_valid;
    ctl.clr       = clr;
    ctl.use_b     = p_use_b;
    ctl.deliver   = (state == ST_FINISH) && out_free;
  end

  assign use_b   = 32'(idx) >= 32'(val);
  assign raddr_a = idx;
  assign raddr_b = idx - val[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b1;   // table memory is not cleared: first item treats it as empty
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
      if (start) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= AW'(MAX_TARGET);
      val <= value;
      clr <= new_set || pending;
    end else if (issue) begin
      idx <= idx - AW'(1);
    end
    p_addr   <= idx;
    p_addr_b <= raddr_b;
    p_use_b  <= use_b;
  end

endmodule

### tb/subset_sum_count_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// subset_sum_count_tb
// Streams sets of values through the subset sum counter under random
// handshake gaps and output stalls. A shadow count table predicts each
// result, which is checked in order against what the block delivers.
// ---------------------------------------------------------------------------
module subset_sum_count_tb;
  import sscnt_pkg::*;

  localparam int          MAX_T       = MAX_TARGET_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          IDLE_PCT    = 38;
  localparam int          PHASE_ITEMS = 68;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               sat;
  } tally_result_t;

  typedef enum int {SK_SMALL, SK_MIXED, SK_ZEROS, SK_NOISE} set_kind_t;

  // shadow of the per-sum count table, fed with every accepted value
  class subset_tally;
    logic [COUNT_W-1:0] tally [MAX_T+1];
    logic               ovf;
    logic [TARGET_W-1:0] target;
    tally_result_t      expected_q[$];
    int                 errors;

    function new();
      start_set();
      target = '0;
      errors = 0;
    endfunction

    function void start_set();
      foreach (tally[i]) tally[i] = '0;
      tally[0] = COUNT_W'(1);
      ovf = 1'b0;
    endfunction

    function void set_target(logic [TARGET_W-1:0] t);
      target = t;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void note_input(logic [VALUE_W-1:0] v, logic ns);
      logic [COUNT_W:0] sum;
      tally_result_t    r;
      if (ns) start_set();
      // walk high to low so each value is used at most once per subset
      if (v <= MAX_T) begin
        for (int s = MAX_T; s >= int'(v); s--) begin
          sum = {1'b0, tally[s]} + {1'b0, tally[s - int'(v)]};
          if (sum > {1'b0, COUNT_MAX}) begin
            tally[s] = COUNT_MAX;
            ovf = 1'b1;
          end else begin
            tally[s] = sum[COUNT_W-1:0];
          end
        end
      end
      r.count = (int'(target) <= MAX_T) ? tally[target] : '0;
      r.sat = ovf;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [COUNT_W-1:0] cnt, logic sat);
      tally_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none expected: count %0d sat %0b", cnt, sat));
        return;
      end
      e = expected_q.pop_front();
      if (cnt !== e.count)
        report($sformatf("subset_count expected %0d got %0d", e.count, cnt));
      if (sat !== e.sat)
        report($sformatf("saturated expected %0b got %0b", e.sat, sat));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sscnt_in_if  in_ch();
  sscnt_out_if out_ch();
  sscnt_cfg_if cfg();

  subset_sum_count #(.MAX_TARGET(MAX_T)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #5 clk = ~clk;

  subset_tally sb;
  int          items_sent;
  int          hold_left;
  bit          no_idle;
  int unsigned cycle_count;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.subset_count, out_ch.saturated);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic ns);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!no_idle && $urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.new_set <= ns;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(v, ns);
    items_sent++;
  endtask

  // only written once every result is back, so the block is idle
  task automatic write_target(input logic [TARGET_W-1:0] t);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg.valid      <= 1'b1;
    cfg.target_sum <= t;
    do @(posedge clk); while (!cfg.ready);
    sb.set_target(t);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_set(input set_kind_t kind, input int len);
    logic [VALUE_W-1:0] v;
    logic               ns;
    for (int i = 0; i < len; i++) begin
      case (kind)
        SK_SMALL: v = VALUE_W'($urandom_range(0, 12));
        SK_MIXED: v = VALUE_W'($urandom_range(0, MAX_T));
        SK_ZEROS: v = ($urandom_range(9) == 0) ? VALUE_W'($urandom_range(1, 8)) : '0;
        default:  v = VALUE_W'($urandom_range(0, 65535));
      endcase
      if (kind == SK_NOISE) ns = ($urandom_range(3) == 0);
      else ns = (i == 0);
      send_item(v, ns);
    end
  endtask

  task automatic send_random_set();
    int r;
    r = $urandom_range(99);
    if (r < 48) send_set(SK_SMALL, $urandom_range(1, 30));
    else if (r < 74) send_set(SK_MIXED, $urandom_range(1, 15));
    else if (r < 78) send_set(SK_ZEROS, $urandom_range(60, 75));
    else send_set(SK_NOISE, $urandom_range(1, 10));
  endtask

  initial begin
    logic [TARGET_W-1:0] targets [7];
    int                  phase_end;

    sb = new();
    items_sent  = 0;
    hold_left   = 0;
    no_idle     = 1'b0;
    cycle_count = 0;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.value    <= '0;
    in_ch.new_set  <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.target_sum <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: table straight from reset, zero, range edges, restarts
    write_target(10'd3);
    send_item(16'd3, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd1023, 1'b0);
    send_item(16'd1024, 1'b0);
    send_item(16'hffff, 1'b0);
    send_item(16'haaaa, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'd0, 1'b1);
    send_item(16'd3, 1'b1);
    send_item(16'd1, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd1, 1'b0);
    write_target(10'd1023);
    send_item(16'd1023, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd1000, 1'b1);
    send_item(16'd23, 1'b0);
    write_target(10'd0);
    send_item(16'd0, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd5, 1'b1);

    targets = '{10'd0, 10'd1023, 10'd7, 10'd0, 10'd1, 10'd0, 10'd2};
    targets[3] = TARGET_W'($urandom_range(0, MAX_T));
    targets[5] = TARGET_W'($urandom_range(0, 40));

    for (int p = 0; p < 7; p++) begin
      write_target(targets[p]);
      phase_end = items_sent + PHASE_ITEMS;
      if (p == 1) hold_left = 6000;  // result side stalls long enough to back up the input
      no_idle = (p == 3);
      if (p == 0) send_set(SK_ZEROS, 70);  // enough doublings to hit the ceiling
      while (items_sent < phase_end) send_random_set();
      no_idle = 1'b0;
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
